// ----- hdl/epc_pkg.sv -----
// Package for the effect page parameter controller.
// Holds the shared constants, the controller state type and the command struct.
// No dependencies.
package epc_pkg;

    // Timing constants of the audio path
    localparam int BLOCK_FRAMES    = 64;
    localparam int DEBOUNCE_BLOCKS = 3;

    // Field widths
    localparam int KNOB_W  = 12;
    localparam int SW_W    = 2;
    localparam int DELAY_W = 17;
    localparam int PARAM_W = 13;
    localparam int CLOCK_W = 32;
    localparam int CNT_W   = 4;
    localparam int SQ_W    = 2 * KNOB_W;
    localparam int SCALE_W = 31;

    // Switch codes
    localparam logic [SW_W-1:0] SW_DOWN   = 2'd0;
    localparam logic [SW_W-1:0] SW_MIDDLE = 2'd1;
    localparam logic [SW_W-1:0] SW_UP     = 2'd2;

    // Page codes
    localparam logic [1:0] PAGE_FOLD  = 2'd0;
    localparam logic [1:0] PAGE_DELAY = 2'd1;
    localparam logic [1:0] PAGE_HOLD  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_WINDOW = 2'd1;

    // Register reset values
    localparam logic [15:0]       TAP_TIMEOUT_RST   = 16'd750;
    localparam logic [KNOB_W-1:0] PICKUP_WINDOW_RST = 12'd64;
    localparam logic [KNOB_W-1:0] PAGE_RST          = 12'd2048;
    localparam logic [KNOB_W-1:0] PAGE4_RST         = 12'd0;
    localparam logic [KNOB_W-1:0] PAGE5_RST         = 12'd3072;
    localparam logic [DELAY_W-1:0] TAPPED_RST       = 17'd16384;

    // Delay curve and clamp
    localparam int DELAY_MIN   = 8;
    localparam int DELAY_MAX   = 96 * 1024;
    localparam int DELAY_SCALE = 96;
    localparam int DELAY_SHIFT = 14;
    localparam int TAP_SAT_BLOCKS = DELAY_MAX / BLOCK_FRAMES;
    localparam int TAP_MIN_BLOCKS = (DELAY_MIN + BLOCK_FRAMES - 1) / BLOCK_FRAMES;

    // Output constants
    localparam logic [PARAM_W-1:0] SEND_OFFSET = 13'd4096;
    localparam logic [PARAM_W-1:0] FB_MAX      = 13'd4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQUARE,
        ST_FINISH
    } t_epc_state;

    typedef struct packed {
        logic load_in;
        logic update;
        logic square;
        logic load_out;
    } t_epc_cmd;

endpackage

// ----- hdl/epc_in_if.sv -----
// Input channel interface: one control snapshot per transaction.
// Depends on epc_pkg for widths.
interface epc_in_if import epc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KNOB_W-1:0] main_knob;
    logic [KNOB_W-1:0] x_knob;
    logic [KNOB_W-1:0] y_knob;
    logic [SW_W-1:0]   switch_position;

    modport source(output valid, main_knob, x_knob, y_knob, switch_position, input ready);
    modport sink(input valid, main_knob, x_knob, y_knob, switch_position, output ready);
endinterface

// ----- hdl/epc_out_if.sv -----
// Output channel interface: nine effect parameters per transaction.
// Depends on epc_pkg for widths.
interface epc_out_if import epc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KNOB_W-1:0]         drive;
    logic signed [PARAM_W-1:0] delay_send;
    logic [DELAY_W-1:0]        delay_time;
    logic [PARAM_W-1:0]        delay_feedback;
    logic [KNOB_W-1:0]         reverb_send;
    logic [KNOB_W-1:0]         reverb_feedback;
    logic signed [PARAM_W-1:0] wet_dry_mix;
    logic [KNOB_W-1:0]         output_level;
    logic                      wavefold_on;

    modport source(output valid, drive, delay_send, delay_time, delay_feedback, reverb_send,
                   reverb_feedback, wet_dry_mix, output_level, wavefold_on, input ready);
    modport sink(input valid, drive, delay_send, delay_time, delay_feedback, reverb_send,
                 reverb_feedback, wet_dry_mix, output_level, wavefold_on, output ready);
endinterface

// ----- hdl/effect_page_parameter_controller.sv -----
// Top level of the effect page parameter controller.
// Joins epc_ctrl and epc_datapath; uses epc_pkg, epc_in_if and epc_out_if.
//
//  channel   | direction | transaction
//  ----------+-----------+------------------------------------------------
//  i_in_ch   | in        | knobs and switch snapshot of one audio block
//  o_out_ch  | out       | nine effect parameters for that block
//  cfg port  | in        | write of tap timeout (0) or pickup window (1)
//
// Each snapshot passes through these steps in order: capture at acceptance, state
// update, squaring multiply, curve scale into the output register. The next snapshot
// is accepted in the cycle after the load; a result waiting in the output register
// stalls the final step only. Reset is synchronous and active low; no clearing pass
// is needed.
module effect_page_parameter_controller import epc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    epc_in_if.sink                i_in_ch,
    epc_out_if.source             o_out_ch
);

    t_epc_cmd cmd;

    epc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_cmd       (cmd)
    );

    epc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_main_knob       (i_in_ch.main_knob),
        .i_x_knob          (i_in_ch.x_knob),
        .i_y_knob          (i_in_ch.y_knob),
        .i_switch_position (i_in_ch.switch_position),
        .o_drive           (o_out_ch.drive),
        .o_delay_send      (o_out_ch.delay_send),
        .o_delay_time      (o_out_ch.delay_time),
        .o_delay_feedback  (o_out_ch.delay_feedback),
        .o_reverb_send     (o_out_ch.reverb_send),
        .o_reverb_feedback (o_out_ch.reverb_feedback),
        .o_wet_dry_mix     (o_out_ch.wet_dry_mix),
        .o_output_level    (o_out_ch.output_level),
        .o_wavefold_on     (o_out_ch.wavefold_on)
    );

endmodule

// ----- hdl/epc_ctrl.sv -----
// Controller FSM: sequences load, update, square and output load for one snapshot.
// Holds the output valid flag. Depends on epc_pkg.
module epc_ctrl import epc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_epc_cmd o_cmd
);

    t_epc_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // State and valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                // Wait here until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/epc_datapath.sv -----
// Datapath: page values, switch debounce, tap tempo, delay curve and output register.
// Driven by the command struct from epc_ctrl. Depends on epc_pkg.
module epc_datapath import epc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_epc_cmd                  i_cmd,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [KNOB_W-1:0]         i_main_knob,
    input  logic [KNOB_W-1:0]         i_x_knob,
    input  logic [KNOB_W-1:0]         i_y_knob,
    input  logic [SW_W-1:0]           i_switch_position,
    output logic [KNOB_W-1:0]         o_drive,
    output logic signed [PARAM_W-1:0] o_delay_send,
    output logic [DELAY_W-1:0]        o_delay_time,
    output logic [PARAM_W-1:0]        o_delay_feedback,
    output logic [KNOB_W-1:0]         o_reverb_send,
    output logic [KNOB_W-1:0]         o_reverb_feedback,
    output logic signed [PARAM_W-1:0] o_wet_dry_mix,
    output logic [KNOB_W-1:0]         o_output_level,
    output logic                      o_wavefold_on
);

    // Configuration
    logic [15:0]        r_tap_timeout;
    logic [KNOB_W-1:0]  r_pickup_window;

    // Latched snapshot
    logic [1:0]         r_mode;
    logic [KNOB_W-1:0]  r_x, r_y;
    logic [SW_W-1:0]    r_sw;

    // Block state
    logic [KNOB_W-1:0]  r_page [8];
    logic [KNOB_W-1:0]  n_page [8];
    logic [SW_W-1:0]    r_stable, n_stable;
    logic [SW_W-1:0]    r_cand, n_cand;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_fold, n_fold;
    logic               r_armed, n_armed;
    logic [CLOCK_W-1:0] r_clk, r_first, n_first, r_last, n_last;
    logic [DELAY_W-1:0] r_tapped, n_tapped;
    logic [KNOB_W-1:0]  r_pick_ref, n_pick_ref;
    logic               r_tap_act, n_tap_act;
    logic [SQ_W-1:0]    r_sq;

    // Update-stage helpers
    logic signed [KNOB_W:0] delta;
    logic                   release_tap;
    logic                   tap_mid;
    logic                   pressed;
    logic                   new_seq;
    logic [CLOCK_W-1:0]     since_last, elapsed;
    logic [DELAY_W-1:0]     tap_time;

    // Finish-stage helpers
    logic [SCALE_W-1:0]     scaled;
    logic [DELAY_W-1:0]     curve;
    logic                   hold;
    logic [PARAM_W-1:0]     send, mix;

    // Configuration writes; other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_timeout   <= TAP_TIMEOUT_RST;
            r_pickup_window <= PICKUP_WINDOW_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TAP_TIMEOUT) r_tap_timeout <= i_cfg_data;
            if (i_cfg_idx == CFG_PICKUP_WINDOW) r_pickup_window <= i_cfg_data[KNOB_W-1:0];
        end
    end

    // Capture snapshot, saturating the unused switch code to up
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_main_knob[KNOB_W-1:KNOB_W-2];
            r_x    <= i_x_knob;
            r_y    <= i_y_knob;
            r_sw   <= i_switch_position[1] ? SW_UP : i_switch_position;
        end
    end

    // Compute next block state from the latched snapshot
    always_comb begin
        n_page     = r_page;
        n_stable   = r_stable;
        n_cand     = r_cand;
        n_cnt      = r_cnt;
        n_armed    = r_armed;
        n_fold     = r_fold;
        n_first    = r_first;
        n_last     = r_last;
        n_tapped   = r_tapped;
        n_pick_ref = r_pick_ref;
        pressed    = 1'b0;

        // Pickup: release the tapped time once X leaves the window
        delta       = $signed({1'b0, r_x}) - $signed({1'b0, r_pick_ref});
        release_tap = (delta > $signed({1'b0, r_pickup_window})) ||
                      (delta < -$signed({1'b0, r_pickup_window}));
        tap_mid     = r_tap_act && !((r_mode == PAGE_DELAY) && release_tap);

        // Page write
        for (int i = 0; i < 8; i++) begin
            if (3'(i) == {r_mode, 1'b0} && !((r_mode == PAGE_DELAY) && tap_mid))
                n_page[i] = r_x;
            if (3'(i) == {r_mode, 1'b1})
                n_page[i] = r_y;
        end

        // Debounce
        if (r_sw != r_cand) begin
            n_cand = r_sw;
            n_cnt  = CNT_W'(1);
        end else if (r_cnt < CNT_W'(DEBOUNCE_BLOCKS)) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (r_stable == r_cand) begin
            if (r_stable != SW_DOWN) n_armed = 1'b1;
        end else begin
            n_stable = r_cand;
            if (r_cand != SW_DOWN) n_armed = 1'b1;
            else pressed = r_armed;
        end

        // Wavefold toggle
        if (pressed && r_mode == PAGE_FOLD) n_fold = !r_fold;

        // Tap tempo
        since_last = r_clk - r_last;
        elapsed    = r_clk - r_first;
        new_seq    = (r_first == '0) || (since_last > {16'd0, r_tap_timeout});
        if (elapsed > CLOCK_W'(TAP_SAT_BLOCKS))
            tap_time = DELAY_W'(DELAY_MAX);
        else if (elapsed < CLOCK_W'(TAP_MIN_BLOCKS))
            tap_time = DELAY_W'(DELAY_MIN);
        else
            tap_time = DELAY_W'(elapsed[DELAY_W-1:0] * DELAY_W'(BLOCK_FRAMES));
        n_tap_act = tap_mid;
        if (pressed && r_mode == PAGE_DELAY) begin
            if (new_seq) begin
                n_first = r_clk;
            end else begin
                n_tapped   = tap_time;
                n_pick_ref = r_x;
                n_tap_act  = 1'b1;
            end
            n_last = r_clk;
        end
    end

    // Block state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                if (i == 4) r_page[i] <= PAGE4_RST;
                else if (i == 5) r_page[i] <= PAGE5_RST;
                else r_page[i] <= PAGE_RST;
            end
            r_stable   <= SW_MIDDLE;
            r_cand     <= SW_MIDDLE;
            r_cnt      <= CNT_W'(DEBOUNCE_BLOCKS);
            r_fold     <= 1'b0;
            r_armed    <= 1'b0;
            r_clk      <= '0;
            r_first    <= '0;
            r_last     <= '0;
            r_tapped   <= TAPPED_RST;
            r_pick_ref <= '0;
            r_tap_act  <= 1'b0;
        end else begin
            // Advance the block clock as the snapshot is taken
            if (i_cmd.load_in) r_clk <= r_clk + CLOCK_W'(1);
            if (i_cmd.update) begin
                r_page     <= n_page;
                r_stable   <= n_stable;
                r_cand     <= n_cand;
                r_cnt      <= n_cnt;
                r_fold     <= n_fold;
                r_armed    <= n_armed;
                r_first    <= n_first;
                r_last     <= n_last;
                r_tapped   <= n_tapped;
                r_pick_ref <= n_pick_ref;
                r_tap_act  <= n_tap_act;
            end
        end
    end

    // Square the delay page's first value
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) r_sq <= r_page[2] * r_page[2];
    end

    // Scale, clamp and apply the page-3 hold
    always_comb begin
        scaled = SCALE_W'(r_sq) * SCALE_W'(DELAY_SCALE);
        curve  = scaled[DELAY_SHIFT+DELAY_W-1:DELAY_SHIFT];
        if (scaled[SCALE_W-1:DELAY_SHIFT] < (SCALE_W-DELAY_SHIFT)'(DELAY_MIN))
            curve = DELAY_W'(DELAY_MIN);
        else if (scaled[SCALE_W-1:DELAY_SHIFT] > (SCALE_W-DELAY_SHIFT)'(DELAY_MAX))
            curve = DELAY_W'(DELAY_MAX);
        hold = (r_mode == PAGE_HOLD) && r_armed && (r_stable == SW_DOWN);
        send = {r_page[1], 1'b0} - SEND_OFFSET;
        mix  = {r_page[6], 1'b0} - SEND_OFFSET;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_delay_time      <= r_tap_act ? r_tapped : curve;
            o_reverb_send     <= r_page[4];
            o_reverb_feedback <= r_page[5];
            o_output_level    <= r_page[7];
            o_wavefold_on     <= r_fold;
            if (hold) begin
                o_drive          <= '0;
                o_delay_send     <= '0;
                o_delay_feedback <= FB_MAX;
                o_wet_dry_mix    <= mix[PARAM_W-1] ? '0 : $signed(mix);
            end else begin
                o_drive          <= r_page[0];
                o_delay_send     <= $signed(send);
                o_delay_feedback <= {1'b0, r_page[3]};
                o_wet_dry_mix    <= $signed(mix);
            end
        end
    end

endmodule

// ----- test/effect_page_parameter_controller_test.sv -----
// Self-checking testbench for the effect page parameter controller.
// Drives knob/switch snapshots and checks each parameter set against a local predictor.
// Depends on epc_pkg, epc_in_if, epc_out_if and the controller RTL.
`timescale 1ns / 1ps

module effect_page_parameter_controller_test;
    import epc_pkg::*;

    localparam int CLK_PERIOD        = 8;
    localparam int RESET_CYCLES      = 11;
    localparam int SETTLE_CYCLES     = 12;
    localparam int LONG_STALL_CYCLES = 300;
    localparam longint RUN_LIMIT_NS  = 4_000_000;
    localparam int KNOB_MAX          = (1 << KNOB_W) - 1;
    localparam int OPENING_ROWS      = 28;
    localparam int TYPED_ROWS        = 3;

    // Codes the package does not name
    localparam logic [SW_W-1:0]      SW_SPARE     = 2'd3;
    localparam logic [1:0]           PAGE_REVERB  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [KNOB_W-1:0] main_knob;
        logic [KNOB_W-1:0] x_knob;
        logic [KNOB_W-1:0] y_knob;
        logic [SW_W-1:0]   switch_position;
    } t_snapshot;

    typedef struct {
        logic [KNOB_W-1:0]         drive;
        logic signed [PARAM_W-1:0] delay_send;
        logic [DELAY_W-1:0]        delay_time;
        logic [PARAM_W-1:0]        delay_feedback;
        logic [KNOB_W-1:0]         reverb_send;
        logic [KNOB_W-1:0]         reverb_feedback;
        logic signed [PARAM_W-1:0] wet_dry_mix;
        logic [KNOB_W-1:0]         output_level;
        logic                      wavefold_on;
    } t_effect_params;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    epc_in_if  in_ch();
    epc_out_if out_ch();

    effect_page_parameter_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: page memory, debouncer, tap tempo and register copies
    logic [KNOB_W-1:0]  page_mem [8];
    logic [SW_W-1:0]    settled_sw;
    logic [SW_W-1:0]    pending_sw;
    int unsigned        pending_count;
    bit                 fold_state;
    bit                 armed;
    logic [31:0]        block_count;
    logic [31:0]        seq_start_block;
    logic [31:0]        prev_tap_block;
    logic [DELAY_W-1:0] tap_delay;
    logic [KNOB_W-1:0]  tap_x_ref;
    bit                 tap_hold_active;
    logic [15:0]        timeout_reg;
    logic [KNOB_W-1:0]  window_reg;

    t_effect_params expected_params [$];
    int snapshots_sent = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_request  = 0;
    int ready_hold_left = 0;
    int tap_x_center   = 2048;

    logic [SW_W-1:0] rest_codes [3] = '{SW_MIDDLE, SW_UP, SW_SPARE};
    logic [1:0] press_pages [6] = '{PAGE_FOLD, PAGE_DELAY, PAGE_DELAY, PAGE_DELAY,
                                    PAGE_HOLD, PAGE_REVERB};

    // Directed snapshots; the first rows carry hand-computed results
    t_snapshot opening_rows [OPENING_ROWS] = '{
        // extremes, switch code three on the delay page
        '{12'd0,    12'd0,    12'd0,    SW_MIDDLE},
        '{12'd4095, 12'd4095, 12'd4095, SW_UP},
        '{12'd1024, 12'd0,    12'd4095, SW_SPARE},
        '{12'd3071, 12'd4095, 12'd0,    SW_UP},
        // down press landing on page 0 toggles wavefold
        '{12'd2048, 12'd0,    12'd4095, SW_DOWN},
        '{12'd0,    12'd1234, 12'd2000, SW_DOWN},
        '{12'd512,  12'd2345, 12'd1000, SW_DOWN},
        '{12'd1023, 12'd4000, 12'd100,  SW_DOWN},
        // held down on page 3: mix floored, then mix kept
        '{12'd3072, 12'd100,  12'd5,    SW_DOWN},
        '{12'd4095, 12'd4095, 12'd4095, SW_DOWN},
        // release on the delay page
        '{12'd1024, 12'd2000, 12'd300,  SW_MIDDLE},
        '{12'd1200, 12'd2000, 12'd300,  SW_MIDDLE},
        '{12'd1600, 12'd2000, 12'd300,  SW_MIDDLE},
        '{12'd2047, 12'd2000, 12'd300,  SW_MIDDLE},
        // first tap starts a sequence
        '{12'd1024, 12'd2000, 12'd400,  SW_DOWN},
        '{12'd1300, 12'd2000, 12'd400,  SW_DOWN},
        '{12'd1800, 12'd2000, 12'd400,  SW_DOWN},
        '{12'd2047, 12'd2000, 12'd400,  SW_DOWN},
        '{12'd1024, 12'd2010, 12'd500,  SW_UP},
        '{12'd1100, 12'd2010, 12'd500,  SW_UP},
        '{12'd1500, 12'd2010, 12'd500,  SW_UP},
        '{12'd2000, 12'd2010, 12'd500,  SW_UP},
        // second tap sets the tapped time
        '{12'd1024, 12'd2020, 12'd600,  SW_DOWN},
        '{12'd1400, 12'd2020, 12'd600,  SW_DOWN},
        '{12'd1700, 12'd2020, 12'd600,  SW_DOWN},
        '{12'd2047, 12'd2020, 12'd600,  SW_DOWN},
        // X inside the pickup window, then outside it
        '{12'd1100, 12'd2050, 12'd650,  SW_MIDDLE},
        '{12'd1100, 12'd2100, 12'd700,  SW_MIDDLE}
    };

    t_effect_params typed_params [TYPED_ROWS] = '{
        '{drive: 12'd0, delay_send: -13'sd4096, delay_time: 17'd24576,
          delay_feedback: 13'd2048, reverb_send: 12'd0, reverb_feedback: 12'd3072,
          wet_dry_mix: 13'sd0, output_level: 12'd2048, wavefold_on: 1'b0},
        '{drive: 12'd0, delay_send: -13'sd4096, delay_time: 17'd24576,
          delay_feedback: 13'd2048, reverb_send: 12'd0, reverb_feedback: 12'd3072,
          wet_dry_mix: 13'sd4094, output_level: 12'd4095, wavefold_on: 1'b0},
        '{drive: 12'd0, delay_send: -13'sd4096, delay_time: 17'd8,
          delay_feedback: 13'd4095, reverb_send: 12'd0, reverb_feedback: 12'd3072,
          wet_dry_mix: 13'sd4094, output_level: 12'd4095, wavefold_on: 1'b0}
    };

    function automatic void reset_predictor();
        for (int i = 0; i < 8; i++) page_mem[i] = PAGE_RST;
        page_mem[4]     = PAGE4_RST;
        page_mem[5]     = PAGE5_RST;
        settled_sw      = SW_MIDDLE;
        pending_sw      = SW_MIDDLE;
        pending_count   = DEBOUNCE_BLOCKS;
        fold_state      = 1'b0;
        armed           = 1'b0;
        block_count     = '0;
        seq_start_block = '0;
        prev_tap_block  = '0;
        tap_delay       = TAPPED_RST;
        tap_x_ref       = '0;
        tap_hold_active = 1'b0;
        timeout_reg     = TAP_TIMEOUT_RST;
        window_reg      = PICKUP_WINDOW_RST;
    endfunction

    function automatic logic [DELAY_W-1:0] clamp_delay_samples(longint unsigned v);
        if (v < DELAY_MIN) return DELAY_W'(DELAY_MIN);
        if (v > DELAY_MAX) return DELAY_W'(DELAY_MAX);
        return v[DELAY_W-1:0];
    endfunction

    // Advance the debouncer one block; report a down press once armed
    function automatic bit settle_switch(logic [SW_W-1:0] req);
        if (req != pending_sw) begin
            pending_sw    = req;
            pending_count = 1;
            return 1'b0;
        end
        if (pending_count < DEBOUNCE_BLOCKS) begin
            pending_count++;
            return 1'b0;
        end
        if (settled_sw == pending_sw) begin
            if (settled_sw != SW_DOWN) armed = 1'b1;
            return 1'b0;
        end
        settled_sw = pending_sw;
        if (settled_sw != SW_DOWN) begin
            armed = 1'b1;
            return 1'b0;
        end
        return armed;
    endfunction

    // Apply one snapshot to the predictor state and form the parameter set
    function automatic t_effect_params predict_effect_params(t_snapshot s);
        logic [1:0]         page;
        logic [SW_W-1:0]    sw;
        logic [31:0]        gap;
        longint unsigned    sq;
        logic [DELAY_W-1:0] dtime;
        int                 delta, drv, snd, fb, mix;
        bit                 pressed, hold;
        t_effect_params     r;

        page = s.main_knob[KNOB_W-1:KNOB_W-2];
        sw   = (s.switch_position > SW_UP) ? SW_UP : s.switch_position;
        block_count = block_count + 32'd1;

        // X straying from the tap reference releases the tapped time
        if (page == PAGE_DELAY && tap_hold_active) begin
            delta = int'(s.x_knob) - int'(tap_x_ref);
            if (delta > int'(window_reg) || delta < -int'(window_reg))
                tap_hold_active = 1'b0;
        end
        if (!(page == PAGE_DELAY && tap_hold_active)) page_mem[{page, 1'b0}] = s.x_knob;
        page_mem[{page, 1'b1}] = s.y_knob;

        pressed = settle_switch(sw);
        if (pressed && page == PAGE_FOLD) fold_state = !fold_state;
        if (pressed && page == PAGE_DELAY) begin
            gap = block_count - prev_tap_block;
            if (seq_start_block == 0 || gap > timeout_reg) begin
                seq_start_block = block_count;
            end else begin
                gap = block_count - seq_start_block;
                sq  = gap;
                tap_delay       = clamp_delay_samples(sq * BLOCK_FRAMES);
                tap_x_ref       = s.x_knob;
                tap_hold_active = 1'b1;
            end
            prev_tap_block = block_count;
        end

        sq    = page_mem[2];
        sq    = (sq * sq * DELAY_SCALE) >> DELAY_SHIFT;
        dtime = tap_hold_active ? tap_delay : clamp_delay_samples(sq);
        drv   = int'(page_mem[0]);
        snd   = 2 * int'(page_mem[1]) - int'(SEND_OFFSET);
        fb    = int'(page_mem[3]);
        mix   = 2 * int'(page_mem[6]) - int'(SEND_OFFSET);

        hold = (page == PAGE_HOLD) && armed && (settled_sw == SW_DOWN);
        if (hold) begin
            if (mix < 0) mix = 0;
            drv = 0;
            snd = 0;
            fb  = int'(FB_MAX);
        end

        r.drive           = drv[KNOB_W-1:0];
        r.delay_send      = snd[PARAM_W-1:0];
        r.delay_time      = dtime;
        r.delay_feedback  = fb[PARAM_W-1:0];
        r.reverb_send     = page_mem[4];
        r.reverb_feedback = page_mem[5];
        r.wet_dry_mix     = mix[PARAM_W-1:0];
        r.output_level    = page_mem[7];
        r.wavefold_on     = fold_state;
        return r;
    endfunction

    // Random knobs on a given page; delay-page X mostly hovers near a center
    function automatic t_snapshot draw_snapshot(logic [1:0] page, logic [SW_W-1:0] sw);
        t_snapshot s;
        int        spread;
        int        xv;

        s.main_knob = {page, 10'($urandom)};
        s.y_knob    = 12'($urandom);
        if (page == PAGE_DELAY && $urandom_range(0, 4) != 0) begin
            spread = int'($urandom_range(0, int'(window_reg) + 40));
            xv     = tap_x_center + int'($urandom_range(0, 2 * spread)) - spread;
            if (xv < 0) xv = 0;
            if (xv > KNOB_MAX) xv = KNOB_MAX;
            s.x_knob = xv[KNOB_W-1:0];
        end else begin
            s.x_knob = 12'($urandom);
        end
        s.switch_position = sw;
        return s;
    endfunction

    function automatic int field_differs(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Offer one snapshot, hold it until taken, then queue its parameter set
    task automatic send_snapshot(input t_snapshot s, input int typed_row = -1);
        t_effect_params predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.main_knob       <= s.main_knob;
        in_ch.x_knob          <= s.x_knob;
        in_ch.y_knob          <= s.y_knob;
        in_ch.switch_position <= s.switch_position;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = predict_effect_params(s);
        expected_params.push_back(typed_row >= 0 ? typed_params[typed_row] : predicted);
        snapshots_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every parameter set has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_params.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers plus the two unused indexes, which must be ignored
    task automatic program_registers(input logic [15:0] timeout_blocks,
                                     input logic [KNOB_W-1:0] window);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TAP_TIMEOUT;
        i_cfg_data <= timeout_blocks;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PICKUP_WINDOW;
        i_cfg_data <= {4'($urandom), window};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SPARE_LO;
        i_cfg_data <= 16'($urandom);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SPARE_HI;
        i_cfg_data <= 16'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_reg = timeout_blocks;
        window_reg  = window;
    endtask

    // One switch gesture: noise, a press on some page, a page-3 hold or a knob sweep
    task automatic play_gesture();
        int              kind;
        int              n;
        logic [1:0]      page;
        logic [1:0]      item_page;
        logic [SW_W-1:0] rest_sw;

        kind    = $urandom_range(0, 9);
        rest_sw = rest_codes[$urandom_range(0, 2)];
        if ($urandom_range(0, 7) == 0) tap_x_center = $urandom_range(0, KNOB_MAX);
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) send_snapshot(draw_snapshot(2'($urandom), 2'($urandom)));
            end
            7: begin
                n = $urandom_range(4, 10);
                repeat (n) send_snapshot(draw_snapshot(PAGE_HOLD, SW_DOWN));
                n = $urandom_range(4, 6);
                repeat (n) send_snapshot(draw_snapshot(2'($urandom), rest_sw));
            end
            8, 9: begin
                n = $urandom_range(2, 6);
                repeat (n) send_snapshot(draw_snapshot(2'($urandom), rest_sw));
            end
            default: begin
                page = press_pages[$urandom_range(0, 5)];
                // a short run of downs is a bounce that must not count as a press
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 6);
                repeat (n) begin
                    item_page = ($urandom_range(0, 5) == 0) ? 2'($urandom) : page;
                    send_snapshot(draw_snapshot(item_page, SW_DOWN));
                end
                n = $urandom_range(4, 6);
                repeat (n) send_snapshot(draw_snapshot(page, rest_sw));
            end
        endcase
    endtask

    task automatic run_gestures(input int count);
        int stop_at;
        stop_at = snapshots_sent + count;
        while (snapshots_sent < stop_at) play_gesture();
    endtask

    // Result side: random back-pressure plus long hold-offs on request
    initial begin : result_ready_drive
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                ready_hold_left = stall_request;
                stall_request   = 0;
            end
            if (ready_hold_left > 0) begin
                ready_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted parameter set with the oldest outstanding one
    always @(posedge i_clk) begin : result_check
        t_effect_params want;
        int             errs;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_params.size() == 0) begin
                $display("%0t: parameter set with no snapshot outstanding", $time);
                mismatches++;
            end else begin
                want = expected_params.pop_front();
                errs = 0;
                errs += field_differs("drive", want.drive, out_ch.drive);
                errs += field_differs("delay_send", want.delay_send, out_ch.delay_send);
                errs += field_differs("delay_time", want.delay_time, out_ch.delay_time);
                errs += field_differs("delay_feedback", want.delay_feedback,
                                      out_ch.delay_feedback);
                errs += field_differs("reverb_send", want.reverb_send, out_ch.reverb_send);
                errs += field_differs("reverb_feedback", want.reverb_feedback,
                                      out_ch.reverb_feedback);
                errs += field_differs("wet_dry_mix", want.wet_dry_mix, out_ch.wet_dry_mix);
                errs += field_differs("output_level", want.output_level, out_ch.output_level);
                errs += field_differs("wavefold_on", want.wavefold_on, out_ch.wavefold_on);
                if (errs != 0) mismatches++;
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int row;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_TAP_TIMEOUT;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.main_knob       = '0;
        in_ch.x_knob          = '0;
        in_ch.y_knob          = '0;
        in_ch.switch_position = SW_MIDDLE;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at reset settings; sender sparse idling, receiver mostly stalled
        send_idle_pct = 27;
        recv_idle_pct = 86;
        for (row = 0; row < OPENING_ROWS; row++) begin
            send_snapshot(opening_rows[row], (row < TYPED_ROWS) ? row : -1);
        end
        drain_results();

        // Shortest timeout and zero window: every tap starts over, any X move releases
        program_registers(16'd1, 12'd0);
        run_gestures(150);
        drain_results();

        // Longest timeout and widest window; idling swapped
        send_idle_pct = 86;
        recv_idle_pct = 27;
        program_registers(16'hFFFF, 12'(KNOB_MAX));
        run_gestures(200);
        drain_results();

        // Same long timeout so the tap sequence keeps growing;
        // open with a long receiver hold-off while snapshots keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_registers(16'hFFFF, 12'd100);
        stall_request = LONG_STALL_CYCLES;
        run_gestures(500);
        drain_results();

        // Moderate random settings
        program_registers(16'($urandom_range(9, 40)), 12'($urandom_range(0, 300)));
        run_gestures(150);
        drain_results();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
